### rtl/sts_pkg.sv
package sts_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int LINE_BITS = 16;
  localparam int LEN_BITS = 24;
  localparam int KIND_BITS = 6;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  localparam logic [KIND_BITS-1:0] K_DOT = 6'd5;
  localparam logic [KIND_BITS-1:0] K_SLASH = 6'd9;
  localparam logic [KIND_BITS-1:0] K_BANG = 6'd11;
  localparam logic [KIND_BITS-1:0] K_IDENT = 6'd19;
  localparam logic [KIND_BITS-1:0] K_STRING = 6'd20;
  localparam logic [KIND_BITS-1:0] K_NUMBER = 6'd21;
  localparam logic [KIND_BITS-1:0] K_KEYWORD0 = 6'd22;
  localparam logic [KIND_BITS-1:0] K_ERROR = 6'd38;
  localparam logic [KIND_BITS-1:0] K_EOF = 6'd39;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_COMMENT, M_OPER, M_IDENT,
    M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_STRING
  } mode_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic err;
    logic [OFFSET_BITS-1:0] start;
    logic [LEN_BITS-1:0] len;
    logic [LINE_BITS-1:0] line;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t t0;
    token_t t1;
    token_t t2;
  } burst_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [LEN_BITS-1:0] span(input logic [OFFSET_BITS-1:0] a,
                                               input logic [OFFSET_BITS-1:0] b);
    logic [OFFSET_BITS-1:0] d;
    d = a - b;
    return (a > b) ? LEN_BITS'(d) : '0;
  endfunction

  function automatic logic [KIND_BITS-1:0] word_kind(input logic [47:0] w,
                                                     input logic [LEN_BITS-1:0] n);
    logic [KIND_BITS-1:0] k;
    k = K_IDENT;
    unique case (n)
      24'd2: begin
        if (w[15:0] == "fi") k = K_KEYWORD0 + 6'd6;
        else if (w[15:0] == "ro") k = K_KEYWORD0 + 6'd8;
      end
      24'd3: begin
        if (w[23:0] == "dna") k = K_KEYWORD0 + 6'd0;
        else if (w[23:0] == "rof") k = K_KEYWORD0 + 6'd4;
        else if (w[23:0] == "nuf") k = K_KEYWORD0 + 6'd5;
        else if (w[23:0] == "lin") k = K_KEYWORD0 + 6'd7;
        else if (w[23:0] == "rav") k = K_KEYWORD0 + 6'd14;
      end
      24'd4: begin
        if (w[31:0] == "esle") k = K_KEYWORD0 + 6'd2;
        else if (w[31:0] == "siht") k = K_KEYWORD0 + 6'd12;
        else if (w[31:0] == "eurt") k = K_KEYWORD0 + 6'd13;
      end
      24'd5: begin
        if (w[39:0] == "ssalc") k = K_KEYWORD0 + 6'd1;
        else if (w[39:0] == "eslaf") k = K_KEYWORD0 + 6'd3;
        else if (w[39:0] == "tnirp") k = K_KEYWORD0 + 6'd9;
        else if (w[39:0] == "repus") k = K_KEYWORD0 + 6'd11;
        else if (w[39:0] == "elihw") k = K_KEYWORD0 + 6'd15;
      end
      24'd6: begin
        if (w == "nruter") k = K_KEYWORD0 + 6'd10;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

### rtl/sts_core.sv
module sts_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          c,
  input  logic                end_in,
  output sts_pkg::burst_t     burst
);

  sts_pkg::mode_t mode_r, mode_nxt;
  logic [1:0] pend_r, pend_nxt;
  logic [sts_pkg::OFFSET_BITS-1:0] tstart_r, tstart_nxt, roff_r, roff_nxt;
  logic [sts_pkg::LINE_BITS-1:0] line_r, line_nxt;
  logic [47:0] word_r, word_nxt;
  logic [sts_pkg::LEN_BITS-1:0] wlen_r, wlen_nxt;

  always_comb begin
    logic [sts_pkg::OFFSET_BITS-1:0] pos, nxt, posm1;
    logic fresh;
    sts_pkg::token_t tk [3];
    logic [1:0] n;
    logic endm;
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    tstart_nxt = tstart_r;
    roff_nxt = roff_r;
    line_nxt = line_r;
    word_nxt = word_r;
    wlen_nxt = wlen_r;
    pos = roff_r;
    nxt = (pos < sts_pkg::OFF_MAX) ? pos + 1'b1 : pos;
    posm1 = (pos > 0) ? pos - 1'b1 : '0;
    n = 2'd0;
    fresh = 1'b0;
    tk[0] = '0;
    tk[1] = '0;
    tk[2] = '0;
    endm = end_in || c == 8'h00;
    if (endm) begin
      unique case (mode_r)
        sts_pkg::M_SLASH: begin
          tk[0] = '{sts_pkg::K_SLASH, 1'b0, tstart_r, sts_pkg::span(pos, tstart_r), line_r};
          n = 2'd1;
        end
        sts_pkg::M_OPER: begin
          tk[0] = '{sts_pkg::K_BANG + {3'd0, pend_r, 1'b0}, 1'b0, tstart_r,
                    sts_pkg::span(pos, tstart_r), line_r};
          n = 2'd1;
        end
        sts_pkg::M_IDENT: begin
          tk[0] = '{sts_pkg::word_kind(word_r, wlen_r), 1'b0, tstart_r,
                    sts_pkg::span(pos, tstart_r), line_r};
          n = 2'd1;
        end
        sts_pkg::M_NUM_INT, sts_pkg::M_NUM_FRAC: begin
          tk[0] = '{sts_pkg::K_NUMBER, 1'b0, tstart_r, sts_pkg::span(pos, tstart_r), line_r};
          n = 2'd1;
        end
        sts_pkg::M_NUM_DOT: begin
          tk[0] = '{sts_pkg::K_NUMBER, 1'b0, tstart_r, sts_pkg::span(posm1, tstart_r), line_r};
          tk[1] = '{sts_pkg::K_DOT, 1'b0, posm1, 24'd1, line_r};
          n = 2'd2;
        end
        sts_pkg::M_STRING: begin
          tk[0] = '{sts_pkg::K_ERROR, 1'b1, tstart_r, sts_pkg::span(pos, tstart_r), line_r};
          n = 2'd1;
        end
        default: n = 2'd0;
      endcase
      tk[n] = '{sts_pkg::K_EOF, 1'b0, pos, 24'd0, line_r};
      n = n + 2'd1;
      mode_nxt = sts_pkg::M_IDLE;
      pend_nxt = '0;
      tstart_nxt = '0;
      roff_nxt = '0;
      line_nxt = 16'd1;
      word_nxt = '0;
      wlen_nxt = '0;
    end else begin
      roff_nxt = nxt;
      unique case (mode_r)
        sts_pkg::M_SLASH: begin
          if (c == "/") mode_nxt = sts_pkg::M_COMMENT;
          else begin
            tk[0] = '{sts_pkg::K_SLASH, 1'b0, tstart_r, sts_pkg::span(pos, tstart_r), line_r};
            n = 2'd1;
            fresh = 1'b1;
          end
        end
        sts_pkg::M_COMMENT: fresh = (c == 8'h0a);
        sts_pkg::M_OPER: begin
          if (c == "=") begin
            tk[0] = '{sts_pkg::K_BANG + {3'd0, pend_r, 1'b1}, 1'b0, tstart_r,
                      sts_pkg::span(nxt, tstart_r), line_r};
            n = 2'd1;
            mode_nxt = sts_pkg::M_IDLE;
          end else begin
            tk[0] = '{sts_pkg::K_BANG + {3'd0, pend_r, 1'b0}, 1'b0, tstart_r,
                      sts_pkg::span(pos, tstart_r), line_r};
            n = 2'd1;
            fresh = 1'b1;
          end
        end
        sts_pkg::M_IDENT: begin
          if (sts_pkg::is_alpha(c) || sts_pkg::is_digit(c)) begin
            if (wlen_r < 24'd6) word_nxt[wlen_r[2:0]*8 +: 8] = c;
            if (wlen_r < sts_pkg::LEN_MAX) wlen_nxt = wlen_r + 1'b1;
          end else begin
            tk[0] = '{sts_pkg::word_kind(word_r, wlen_r), 1'b0, tstart_r,
                      sts_pkg::span(pos, tstart_r), line_r};
            n = 2'd1;
            fresh = 1'b1;
          end
        end
        sts_pkg::M_NUM_INT: begin
          if (c == ".") mode_nxt = sts_pkg::M_NUM_DOT;
          else if (!sts_pkg::is_digit(c)) begin
            tk[0] = '{sts_pkg::K_NUMBER, 1'b0, tstart_r, sts_pkg::span(pos, tstart_r), line_r};
            n = 2'd1;
            fresh = 1'b1;
          end
        end
        sts_pkg::M_NUM_DOT: begin
          if (sts_pkg::is_digit(c)) mode_nxt = sts_pkg::M_NUM_FRAC;
          else begin
            tk[0] = '{sts_pkg::K_NUMBER, 1'b0, tstart_r,
                      sts_pkg::span(posm1, tstart_r), line_r};
            tk[1] = '{sts_pkg::K_DOT, 1'b0, posm1, 24'd1, line_r};
            n = 2'd2;
            fresh = 1'b1;
          end
        end
        sts_pkg::M_NUM_FRAC: begin
          if (!sts_pkg::is_digit(c)) begin
            tk[0] = '{sts_pkg::K_NUMBER, 1'b0, tstart_r, sts_pkg::span(pos, tstart_r), line_r};
            n = 2'd1;
            fresh = 1'b1;
          end
        end
        sts_pkg::M_STRING: begin
          if (c == 8'h22) begin
            tk[0] = '{sts_pkg::K_STRING, 1'b0, tstart_r, sts_pkg::span(nxt, tstart_r), line_r};
            n = 2'd1;
            mode_nxt = sts_pkg::M_IDLE;
          end else if (c == 8'h0a && line_r < sts_pkg::LINE_MAX) begin
            line_nxt = line_r + 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase
      if (fresh) begin
        mode_nxt = sts_pkg::M_IDLE;
        tk[n] = '{sts_pkg::K_ERROR, 1'b0, pos, 24'd1, line_r};
        priority case (c)
          8'h20, 8'h0d, 8'h09: ;
          8'h0a: if (line_r < sts_pkg::LINE_MAX) line_nxt = line_r + 1'b1;
          "(": begin tk[n].kind = 6'd0; n = n + 2'd1; end
          ")": begin tk[n].kind = 6'd1; n = n + 2'd1; end
          "{": begin tk[n].kind = 6'd2; n = n + 2'd1; end
          "}": begin tk[n].kind = 6'd3; n = n + 2'd1; end
          ",": begin tk[n].kind = 6'd4; n = n + 2'd1; end
          ".": begin tk[n].kind = 6'd5; n = n + 2'd1; end
          "-": begin tk[n].kind = 6'd6; n = n + 2'd1; end
          "+": begin tk[n].kind = 6'd7; n = n + 2'd1; end
          ";": begin tk[n].kind = 6'd8; n = n + 2'd1; end
          "*": begin tk[n].kind = 6'd10; n = n + 2'd1; end
          "/": begin mode_nxt = sts_pkg::M_SLASH; tstart_nxt = pos; end
          8'h22: begin mode_nxt = sts_pkg::M_STRING; tstart_nxt = pos; end
          "!": begin mode_nxt = sts_pkg::M_OPER; tstart_nxt = pos; pend_nxt = 2'd0; end
          "=": begin mode_nxt = sts_pkg::M_OPER; tstart_nxt = pos; pend_nxt = 2'd1; end
          ">": begin mode_nxt = sts_pkg::M_OPER; tstart_nxt = pos; pend_nxt = 2'd2; end
          "<": begin mode_nxt = sts_pkg::M_OPER; tstart_nxt = pos; pend_nxt = 2'd3; end
          default: begin
            if (sts_pkg::is_alpha(c)) begin
              mode_nxt = sts_pkg::M_IDENT;
              tstart_nxt = pos;
              word_nxt = {40'd0, c};
              wlen_nxt = 24'd1;
            end else if (sts_pkg::is_digit(c)) begin
              mode_nxt = sts_pkg::M_NUM_INT;
              tstart_nxt = pos;
            end else begin
              n = n + 2'd1;
            end
          end
        endcase
      end
    end
    burst.count = n;
    burst.t0 = tk[0];
    burst.t1 = tk[1];
    burst.t2 = tk[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sts_pkg::M_IDLE;
      pend_r <= '0;
      tstart_r <= '0;
      roff_r <= '0;
      line_r <= 16'd1;
      word_r <= '0;
      wlen_r <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      tstart_r <= tstart_nxt;
      roff_r <= roff_nxt;
      line_r <= line_nxt;
      word_r <= word_nxt;
      wlen_r <= wlen_nxt;
    end
  end

endmodule

### rtl/sts_out_buf.sv
module sts_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  sts_pkg::burst_t burst,
  output logic            can_load,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [71:0]     out_tdata,
  output logic            out_tlast
);

  sts_pkg::token_t tok_r [3];
  logic [1:0] cnt_r, idx_r;
  logic [1:0] rem;
  logic done;

  assign out_tvalid = cnt_r != 2'd0;
  assign rem = cnt_r - idx_r;
  assign out_tlast = rem == 2'd1;
  assign done = out_tvalid && out_tready && out_tlast;
  assign can_load = !out_tvalid || done;
  assign out_tdata = {1'b0, tok_r[idx_r].line, tok_r[idx_r].len,
                      tok_r[idx_r].start, tok_r[idx_r].err, tok_r[idx_r].kind};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load && can_load) begin
      cnt_r <= burst.count;
      idx_r <= '0;
    end else if (done) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (out_tvalid && out_tready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      tok_r[0] <= burst.t0;
      tok_r[1] <= burst.t1;
      tok_r[2] <= burst.t2;
    end
  end

endmodule

### rtl/script_token_scanner_unit.sv
// Streaming lexer for a small scripting language.
// The slave channel takes one source byte per transfer in in_tdata with
// end of text in in_tuser; a zero byte also ends the text. The master
// channel delivers tokens: kind, error flag, start offset, length and line,
// with out_tlast on the final token caused by one input byte.
// Each accepted byte is scanned in the cycle it is accepted; its tokens,
// zero to three, appear from the next cycle, one per cycle while out_tready
// is high. A byte that causes no token is absorbed at one byte per cycle.
// A byte with tokens is followed by a new byte as soon as its last token
// transfers, so plain text streams at one byte per cycle while out_tready
// is high; the output buffer sets that figure. End of text flushes the
// pending token, emits EOF and returns the scanner to its reset state for
// a new text. Reset clears the scanner to offset 0 and line 1 and empties
// the output. When the receiver stalls, in_tready falls once a byte's
// tokens are waiting, and everything holds until they are taken.
module script_token_scanner_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // text_byte
  input  logic        in_tuser,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // token_kind, error_kind, start_offset,
                                  // token_length, line_number
  output logic        out_tlast   // last_of_run
);

  sts_pkg::burst_t burst;
  logic can_load;
  logic step;

  assign in_tready = can_load;
  assign step = in_tvalid && can_load;

  sts_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .c      (in_tdata),
    .end_in (in_tuser),
    .burst  (burst)
  );

  sts_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .burst      (burst),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
